// File: rtl/tmsl_pkg.sv
// Shared types and constants for the telemetry max-hold snapshot logger.
// No dependencies; used by every module of the block.
package tmsl_pkg;

  localparam logic [1:0] OP_TEL  = 2'd0;
  localparam logic [1:0] OP_BAT  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic [1:0] CFG_SWITCH_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_LOG_INTERVAL     = 2'd1;
  localparam logic [1:0] CFG_FLUSH_INTERVAL   = 2'd2;
  localparam logic [1:0] CFG_LPF_ALPHA        = 2'd3;

  localparam int CFG_DATA_W = 20;

  localparam logic [11:0] RST_SWITCH_THRESHOLD = 12'd1750;
  localparam logic [15:0] RST_LOG_INTERVAL     = 16'd200;
  localparam logic [19:0] RST_FLUSH_INTERVAL   = 20'd10000;
  localparam logic [8:0]  RST_LPF_ALPHA        = 9'd243;
  localparam logic [8:0]  ALPHA_ONE            = 9'd256;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  channel;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] erpm;
    logic [7:0]  temperature;
    logic [31:0] now_ms;
    logic [11:0] switch_us;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] time_ms;
    logic [15:0] vbat_filtered;
    logic [2:0]  esc_channel;
    logic [15:0] esc_voltage;
    logic [15:0] esc_current;
    logic [15:0] esc_erpm;
    logic [7:0]  esc_temperature;
    logic        flush;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [11:0] switch_threshold_us;
    logic [15:0] log_interval_ms;
    logic [19:0] flush_interval_ms;
    logic [8:0]  lpf_alpha;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic        sw_hi;
    logic [7:0]  channel;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] erpm;
    logic [7:0]  temperature;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

// File: rtl/tmsl_front.sv
// Front end: accepts input beats, drops ones with no effect, classifies the rest.
// Depends on tmsl_pkg; feeds tmsl_cmdq.
module tmsl_front #(
  parameter int ESC_CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  tmsl_pkg::in_t     in_data,
  input  logic [11:0]       switch_threshold_us,
  input  logic              q_full,
  output logic              q_push,
  output tmsl_pkg::cmd_t    q_data
);

  logic           fv_r;
  tmsl_pkg::cmd_t cmd_r;
  logic           accept;
  logic           keep;

  assign in_full = fv_r && q_full;
  assign q_push  = fv_r && !q_full;
  assign accept  = in_push && !in_full;
  assign q_data  = cmd_r;

  assign keep = ((in_data.op == tmsl_pkg::OP_TEL) &&
                 (in_data.channel < 8'(ESC_CHANNELS))) ||
                (in_data.op == tmsl_pkg::OP_BAT) ||
                (in_data.op == tmsl_pkg::OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (accept) begin
      fv_r <= keep;
    end else if (q_push) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      cmd_r.op          <= in_data.op;
      cmd_r.sw_hi       <= (in_data.switch_us >= switch_threshold_us);
      cmd_r.channel     <= in_data.channel;
      cmd_r.voltage     <= in_data.voltage;
      cmd_r.current     <= in_data.current;
      cmd_r.erpm        <= in_data.erpm;
      cmd_r.temperature <= in_data.temperature;
      cmd_r.now_ms      <= in_data.now_ms;
    end
  end

endmodule

// File: rtl/tmsl_cmdq.sv
// Two-entry command queue between the front end and the back end.
// Depends on tmsl_pkg.
module tmsl_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  tmsl_pkg::cmd_t  wdata,
  input  logic            pop,
  output logic            empty,
  output tmsl_pkg::cmd_t  rdata
);

  tmsl_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// File: rtl/tmsl_back.sv
// Back end: channel tables, battery filter, snapshot sequencer and result register.
// Depends on tmsl_pkg; fed by tmsl_cmdq.
module tmsl_back #(
  parameter int ESC_CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tmsl_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  tmsl_pkg::cmd_t  q_data,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output tmsl_pkg::out_t  out_data
);

  localparam int CW = (ESC_CHANNELS > 1) ? $clog2(ESC_CHANNELS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BAT   = 3'd1;
  localparam logic [2:0] ST_EJECT = 3'd2;
  localparam logic [2:0] ST_HDR   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [2:0]              st_r, st_nxt;
  logic [ESC_CHANNELS-1:0] present_r;
  logic [15:0]             volt_r [ESC_CHANNELS];
  logic [15:0]             cur_r  [ESC_CHANNELS];
  logic [15:0]             erpm_r [ESC_CHANNELS];
  logic [7:0]              temp_r [ESC_CHANNELS];
  logic [15:0]             vbat_r;
  logic [31:0]             last_log_r;
  logic [31:0]             last_flush_r;
  logic [31:0]             now_r;
  logic                    flush_due_r;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [24:0]             prod_a_r;
  logic [24:0]             prod_b_r;
  logic                    ov_r;
  tmsl_pkg::out_t          od_r, od_nxt;

  logic          out_free;
  logic          emit;
  logic          tel_wr;
  logic          clr_wr;
  logic          bat_start;
  logic          tick_log;
  logic          log_zero;
  logic          flush_upd;
  logic [CW-1:0] rd_idx;
  logic          rd_present;
  logic          higher;
  logic [ESC_CHANNELS-1:0] above;
  logic [31:0]   log_diff;
  logic [31:0]   flush_diff;
  logic          log_due;
  logic          flush_due;
  logic [8:0]    alpha_sat;
  logic [8:0]    beta;
  logic [25:0]   acc;
  logic [7:0]    idx_w;

  assign out_free   = !ov_r || out_pop;
  assign rd_idx     = (st_r == ST_SCAN) ? idx_r : q_data.channel[CW-1:0];
  assign rd_present = present_r[rd_idx];
  assign above      = present_r >> idx_r;
  assign higher     = |(above >> 1);
  assign log_diff   = q_data.now_ms - last_log_r;
  assign flush_diff = q_data.now_ms - last_flush_r;
  assign log_due    = log_diff >= {16'd0, cfg.log_interval_ms};
  assign flush_due  = flush_diff >= {12'd0, cfg.flush_interval_ms};
  assign alpha_sat  = (cfg.lpf_alpha > tmsl_pkg::ALPHA_ONE) ? tmsl_pkg::ALPHA_ONE
                                                           : cfg.lpf_alpha;
  assign beta       = tmsl_pkg::ALPHA_ONE - alpha_sat;
  assign acc        = {1'b0, prod_a_r} + {1'b0, prod_b_r};
  assign idx_w      = 8'(idx_r);
  assign out_empty  = !ov_r;
  assign out_data   = od_r;

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    tel_wr    = 1'b0;
    clr_wr    = 1'b0;
    bat_start = 1'b0;
    tick_log  = 1'b0;
    log_zero  = 1'b0;
    flush_upd = 1'b0;
    od_nxt    = '0;
    od_nxt.time_ms = now_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          priority if (q_data.op == tmsl_pkg::OP_TEL) begin
            tel_wr = 1'b1;
          end else if (q_data.op == tmsl_pkg::OP_BAT) begin
            bat_start = 1'b1;
            st_nxt    = ST_BAT;
          end else if (q_data.op == tmsl_pkg::OP_TICK) begin
            if (!q_data.sw_hi) begin
              if (last_log_r != 32'd0) begin
                log_zero = 1'b1;
                st_nxt   = ST_EJECT;
              end
            end else if (log_due) begin
              tick_log  = 1'b1;
              flush_upd = flush_due;
              st_nxt    = ST_HDR;
            end
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_BAT: begin
        st_nxt = ST_IDLE;
      end
      ST_EJECT: begin
        if (out_free) begin
          emit         = 1'b1;
          od_nxt.kind  = tmsl_pkg::KIND_FLUSH;
          od_nxt.flush = 1'b1;
          od_nxt.last  = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (out_free) begin
          emit                 = 1'b1;
          od_nxt.kind          = tmsl_pkg::KIND_HDR;
          od_nxt.vbat_filtered = vbat_r;
          od_nxt.last          = !(|present_r);
          od_nxt.flush         = !(|present_r) && flush_due_r;
          idx_nxt              = '0;
          st_nxt               = (|present_r) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!rd_present) begin
          idx_nxt = idx_r + CW'(1);
        end else if (out_free) begin
          emit                   = 1'b1;
          clr_wr                 = 1'b1;
          od_nxt.kind            = tmsl_pkg::KIND_ROW;
          od_nxt.esc_channel     = idx_w[2:0];
          od_nxt.esc_voltage     = volt_r[idx_r];
          od_nxt.esc_current     = cur_r[idx_r];
          od_nxt.esc_erpm        = erpm_r[idx_r];
          od_nxt.esc_temperature = temp_r[idx_r];
          od_nxt.last            = !higher;
          od_nxt.flush           = !higher && flush_due_r;
          idx_nxt                = idx_r + CW'(1);
          if (!higher) st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      idx_r        <= '0;
      present_r    <= '0;
      vbat_r       <= 16'd0;
      last_log_r   <= 32'd0;
      last_flush_r <= 32'd0;
      flush_due_r  <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (tel_wr) present_r[rd_idx] <= 1'b1;
      if (st_r == ST_BAT) vbat_r <= acc[23:8];
      if (tick_log) begin
        last_log_r  <= q_data.now_ms;
        flush_due_r <= flush_due;
      end else if (log_zero) begin
        last_log_r <= 32'd0;
      end
      if (flush_upd) last_flush_r <= q_data.now_ms;
      if (emit)         ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) now_r <= q_data.now_ms;
    if (bat_start) begin
      prod_a_r <= 25'(alpha_sat) * 25'(q_data.voltage);
      prod_b_r <= 25'(beta) * 25'(vbat_r);
    end
    if (emit) od_r <= od_nxt;
    if (tel_wr) begin
      volt_r[rd_idx] <= q_data.voltage;
      if (!rd_present || (q_data.current > cur_r[rd_idx]))
        cur_r[rd_idx] <= q_data.current;
      if (!rd_present || (q_data.erpm > erpm_r[rd_idx]))
        erpm_r[rd_idx] <= q_data.erpm;
      if (!rd_present || (q_data.temperature > temp_r[rd_idx]))
        temp_r[rd_idx] <= q_data.temperature;
    end else if (clr_wr) begin
      cur_r[rd_idx]  <= 16'd0;
      erpm_r[rd_idx] <= 16'd0;
      temp_r[rd_idx] <= 8'd0;
    end
  end

endmodule

// File: rtl/telemetry_maxhold_snapshot_logger_core.sv
// Top level of the telemetry max-hold snapshot logger: config registers,
// front end, command queue and back end. Depends on tmsl_pkg and all tmsl_ modules.
//
// Items enter through a queue-style port; a one-beat front register and a
// two-deep command queue decouple intake from execution. In the back end a
// telemetry beat is written as it is popped, a battery sample is multiplied,
// then added and scaled in ST_BAT, and a snapshotting process tick emits a
// header, then walks the channel table one entry a cycle (stalling while the
// single result register is full), emitting at most one result per cycle.
// An eject flush leaves from ST_EJECT. Results wait in that register until popped.
module telemetry_maxhold_snapshot_logger_core #(
  parameter int ESC_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  tmsl_pkg::in_t                  in_data,
  output logic                           out_empty,
  input  logic                           out_pop,
  output tmsl_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [tmsl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tmsl_pkg::cfg_t cfg_r;
  logic           q_full;
  logic           q_push;
  tmsl_pkg::cmd_t q_wdata;
  logic           q_empty;
  logic           q_pop;
  tmsl_pkg::cmd_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_threshold_us <= tmsl_pkg::RST_SWITCH_THRESHOLD;
      cfg_r.log_interval_ms     <= tmsl_pkg::RST_LOG_INTERVAL;
      cfg_r.flush_interval_ms   <= tmsl_pkg::RST_FLUSH_INTERVAL;
      cfg_r.lpf_alpha           <= tmsl_pkg::RST_LPF_ALPHA;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tmsl_pkg::CFG_SWITCH_THRESHOLD: cfg_r.switch_threshold_us <= cfg_wdata[11:0];
        tmsl_pkg::CFG_LOG_INTERVAL:     cfg_r.log_interval_ms     <= cfg_wdata[15:0];
        tmsl_pkg::CFG_FLUSH_INTERVAL:   cfg_r.flush_interval_ms   <= cfg_wdata[19:0];
        tmsl_pkg::CFG_LPF_ALPHA:        cfg_r.lpf_alpha           <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  tmsl_front #(
    .ESC_CHANNELS(ESC_CHANNELS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data            (in_data),
    .switch_threshold_us(cfg_r.switch_threshold_us),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_wdata)
  );

  tmsl_cmdq u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .full (q_full),
    .wdata(q_wdata),
    .pop  (q_pop),
    .empty(q_empty),
    .rdata(q_rdata)
  );

  tmsl_back #(
    .ESC_CHANNELS(ESC_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_eject_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind == tmsl_pkg::KIND_FLUSH) |->
      (out_data.flush && out_data.last))
    else $error("eject flush without flush and last");

  a_vbat_header_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind != tmsl_pkg::KIND_HDR) |->
      (out_data.vbat_filtered == 16'd0))
    else $error("battery value outside header");

  a_flush_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.flush) |-> out_data.last)
    else $error("flush mark before final result");

endmodule

// File: tb/telemetry_maxhold_snapshot_logger_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for telemetry_maxhold_snapshot_logger_core: queue-fed driver,
// popping monitor and an in-bench snapshot predictor compared beat by beat.
// Depends on tmsl_pkg and the block's RTL.
module telemetry_maxhold_snapshot_logger_core_test;

  localparam int NCH = 8;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  tmsl_pkg::in_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  tmsl_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = tmsl_pkg::CFG_SWITCH_THRESHOLD;
  logic [tmsl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  telemetry_maxhold_snapshot_logger_core #(.ESC_CHANNELS(NCH)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // logger state as the predictor sees it
  logic [11:0] thr_us = tmsl_pkg::RST_SWITCH_THRESHOLD;
  logic [15:0] log_iv = tmsl_pkg::RST_LOG_INTERVAL;
  logic [19:0] flush_iv = tmsl_pkg::RST_FLUSH_INTERVAL;
  logic [8:0]  alpha = tmsl_pkg::RST_LPF_ALPHA;
  logic        seen [NCH];
  logic [15:0] volt_held [NCH];
  logic [15:0] cur_max [NCH];
  logic [15:0] erpm_max [NCH];
  logic [7:0]  temp_max [NCH];
  logic [15:0] vbat_lpf = '0;
  logic [31:0] last_log_ms = '0;
  logic [31:0] last_flush_ms = '0;

  tmsl_pkg::in_t  pending [$];
  tmsl_pkg::out_t rows_due [$];
  tmsl_pkg::out_t want_row;
  string diff_field;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked = 0;
  int stalls_done = 0;
  int rx_hold = 0;
  int quiet_cycles = 0;
  logic in_took = 1'b0;
  logic [31:0] tick_ms = '0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic tmsl_pkg::out_t blank_row(logic [1:0] kind, logic [31:0] t);
    tmsl_pkg::out_t r;
    r = '0;
    r.kind = kind;
    r.time_ms = t;
    return r;
  endfunction

  function automatic void predict_log(tmsl_pkg::in_t it);
    tmsl_pkg::out_t r;
    logic [31:0] a;
    logic [31:0] acc;
    logic do_flush;
    int ch;
    ch = int'(it.channel);
    case (it.op)
      tmsl_pkg::OP_TEL: begin
        if (it.channel < NCH) begin
          if (!seen[ch]) begin
            seen[ch] = 1'b1;
            volt_held[ch] = '0;
            cur_max[ch] = '0;
            erpm_max[ch] = '0;
            temp_max[ch] = '0;
          end
          if (it.current > cur_max[ch]) cur_max[ch] = it.current;
          if (it.erpm > erpm_max[ch]) erpm_max[ch] = it.erpm;
          if (it.temperature > temp_max[ch]) temp_max[ch] = it.temperature;
          volt_held[ch] = it.voltage;
        end
      end
      tmsl_pkg::OP_BAT: begin
        a = (alpha > tmsl_pkg::ALPHA_ONE) ? 32'(tmsl_pkg::ALPHA_ONE) : 32'(alpha);
        acc = a * 32'(it.voltage) + (32'(tmsl_pkg::ALPHA_ONE) - a) * 32'(vbat_lpf);
        vbat_lpf = acc[23:8];
      end
      tmsl_pkg::OP_TICK: begin
        if (it.switch_us < thr_us) begin
          if (last_log_ms != 0) begin
            r = blank_row(tmsl_pkg::KIND_FLUSH, it.now_ms);
            r.flush = 1'b1;
            r.last = 1'b1;
            rows_due.push_back(r);
            last_log_ms = '0;
          end
        end else if (32'(it.now_ms - last_log_ms) >= 32'(log_iv)) begin
          do_flush = (32'(it.now_ms - last_flush_ms) >= 32'(flush_iv));
          r = blank_row(tmsl_pkg::KIND_HDR, it.now_ms);
          r.vbat_filtered = vbat_lpf;
          rows_due.push_back(r);
          for (int i = 0; i < NCH; i++) begin
            if (seen[i]) begin
              r = blank_row(tmsl_pkg::KIND_ROW, it.now_ms);
              r.esc_channel = 3'(i);
              r.esc_voltage = volt_held[i];
              r.esc_current = cur_max[i];
              r.esc_erpm = erpm_max[i];
              r.esc_temperature = temp_max[i];
              rows_due.push_back(r);
              cur_max[i] = '0;
              erpm_max[i] = '0;
              temp_max[i] = '0;
            end
          end
          r = rows_due.pop_back();
          r.last = 1'b1;
          r.flush = do_flush;
          rows_due.push_back(r);
          if (do_flush) last_flush_ms = it.now_ms;
          last_log_ms = it.now_ms;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string row_diff(tmsl_pkg::out_t e, tmsl_pkg::out_t g);
    if (g.kind !== e.kind) return "kind";
    if (g.time_ms !== e.time_ms) return "time_ms";
    if (g.vbat_filtered !== e.vbat_filtered) return "vbat_filtered";
    if (g.esc_channel !== e.esc_channel) return "esc_channel";
    if (g.esc_voltage !== e.esc_voltage) return "esc_voltage";
    if (g.esc_current !== e.esc_current) return "esc_current";
    if (g.esc_erpm !== e.esc_erpm) return "esc_erpm";
    if (g.esc_temperature !== e.esc_temperature) return "esc_temperature";
    if (g.flush !== e.flush) return "flush";
    if (g.last !== e.last) return "last";
    return "";
  endfunction

  // monitor: result beats checked first, then accepted input beats predicted
  always @(posedge clk) begin
    in_took <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (rows_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: got %h", out_data);
        end else begin
          want_row = rows_due.pop_front();
          diff_field = row_diff(want_row, out_data);
          if (diff_field != "") begin
            errors++;
            if (errors <= 10)
              $display("mismatch in %s: expected %h, got %h", diff_field, want_row, out_data);
          end
        end
      end
      if (in_push && !in_full) begin
        predict_log(in_data);
        void'(pending.pop_front());
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && !in_took)) begin
      if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_push <= 1'b1;
        in_data <= pending[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (stalls_asked != stalls_done) begin
      stalls_done = stalls_done + 1;
      rx_hold = STALL_CYCLES;
      out_pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[telemetry_maxhold_snapshot_logger_core] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [tmsl_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tmsl_pkg::CFG_SWITCH_THRESHOLD: thr_us = val[11:0];
      tmsl_pkg::CFG_LOG_INTERVAL:     log_iv = val[15:0];
      tmsl_pkg::CFG_FLUSH_INTERVAL:   flush_iv = val[19:0];
      tmsl_pkg::CFG_LPF_ALPHA:        alpha = val[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sender pause: every beat accepted, every row popped, then the block settles
  task automatic drain();
    while (pending.size() != 0 || rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic tmsl_pkg::in_t tel_item(logic [7:0] ch, logic [15:0] v,
                                             logic [15:0] c, logic [15:0] e,
                                             logic [7:0] t);
    tmsl_pkg::in_t it;
    it = '0;
    it.op = tmsl_pkg::OP_TEL;
    it.channel = ch;
    it.voltage = v;
    it.current = c;
    it.erpm = e;
    it.temperature = t;
    return it;
  endfunction

  function automatic tmsl_pkg::in_t bat_item(logic [15:0] v);
    tmsl_pkg::in_t it;
    it = '0;
    it.op = tmsl_pkg::OP_BAT;
    it.voltage = v;
    return it;
  endfunction

  function automatic tmsl_pkg::in_t tick_item(logic [31:0] now, logic [11:0] sw);
    tmsl_pkg::in_t it;
    it = '0;
    it.op = tmsl_pkg::OP_TICK;
    it.now_ms = now;
    it.switch_us = sw;
    return it;
  endfunction

  task automatic queue_random(int n);
    tmsl_pkg::in_t it;
    logic [127:0] rnd;
    int counted;
    int pick;
    counted = 0;
    while (counted < n) begin
      rnd = {$urandom, $urandom, $urandom, $urandom};
      it = rnd[$bits(tmsl_pkg::in_t)-1:0];
      pick = int'($urandom_range(99));
      if (pick < 45) begin
        it.op = tmsl_pkg::OP_TEL;
        if ($urandom_range(9) == 0) it.channel = 8'($urandom_range(255, NCH));
        else it.channel = 8'($urandom_range(NCH - 1));
        if ($urandom_range(1) == 0) begin
          it.current = 16'($urandom_range(500));
          it.erpm = 16'($urandom_range(500));
          it.temperature = 8'($urandom_range(60));
        end
      end else if (pick < 60) begin
        it.op = tmsl_pkg::OP_BAT;
      end else if (pick < 95) begin
        it.op = tmsl_pkg::OP_TICK;
        if ($urandom_range(19) == 0) tick_ms = $urandom;
        else tick_ms = tick_ms + $urandom_range(32'(log_iv) * 32'd3 / 32'd2 + 32'd1);
        it.now_ms = tick_ms;
        if (thr_us != 0 && $urandom_range(4) == 0)
          it.switch_us = 12'($urandom_range(thr_us - 12'd1));
        else it.switch_us = 12'($urandom_range(4095, thr_us));
      end else begin
        it.op = OP_NONE;
      end
      if (!(it.op == OP_NONE || (it.op == tmsl_pkg::OP_TEL && it.channel >= NCH))) counted++;
      pending.push_back(it);
    end
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      seen[i] = 1'b0;
      volt_held[i] = '0;
      cur_max[i] = '0;
      erpm_max[i] = '0;
      temp_max[i] = '0;
    end
    send_idle_pct = 38;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings
    pending.push_back(tick_item(32'd0, 12'd4095));
    pending.push_back(tel_item(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending.push_back(tel_item(8'd7, 16'd1234, 16'd10, 16'd20, 8'd30));
    pending.push_back(tel_item(8'd8, 16'd1, 16'd2, 16'd3, 8'd4));
    pending.push_back(tel_item(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    pending.push_back(bat_item(16'hFFFF));
    pending.push_back(bat_item(16'd0));
    pending.push_back(bat_item(16'hFFFF));
    pending.push_back(tick_item(32'd200, 12'd1750));
    pending.push_back(tel_item(8'd0, 16'd1, 16'd5, 16'd6, 8'd7));
    pending.push_back(tick_item(32'd399, 12'd4095));
    pending.push_back(tick_item(32'd400, 12'd4095));
    pending.push_back(tick_item(32'd500, 12'd1749));
    pending.push_back(tick_item(32'd600, 12'd0));
    pending.push_back({OP_NONE, {108{1'b1}}});
    pending.push_back(tick_item(32'hFFFF_FFFF, 12'd4095));
    pending.push_back(tel_item(8'd3, 16'd0, 16'd0, 16'd0, 8'd0));
    pending.push_back(tick_item(32'h0000_0100, 12'd2000));
    // snapshot at time zero leaves nothing to eject
    pending.push_back(tick_item(32'd0, 12'd4095));
    pending.push_back(tick_item(32'd300, 12'd100));
    pending.push_back(tick_item(32'd10, 12'd4095));
    drain();

    // threshold upper bits dropped, so the switch is always high
    cfg_write(tmsl_pkg::CFG_SWITCH_THRESHOLD, 20'hFF000);
    cfg_write(tmsl_pkg::CFG_LOG_INTERVAL, 20'd0);
    cfg_write(tmsl_pkg::CFG_FLUSH_INTERVAL, 20'd1);
    cfg_write(tmsl_pkg::CFG_LPF_ALPHA, 20'd511);
    @(posedge clk);
    queue_random(135);
    drain();

    send_idle_pct = 81;
    recv_idle_pct = 38;
    cfg_write(tmsl_pkg::CFG_SWITCH_THRESHOLD, 20'd4095);
    cfg_write(tmsl_pkg::CFG_LOG_INTERVAL, 20'd65535);
    cfg_write(tmsl_pkg::CFG_FLUSH_INTERVAL, 20'hFFFFF);
    cfg_write(tmsl_pkg::CFG_LPF_ALPHA, 20'd0);
    @(posedge clk);
    queue_random(135);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(tmsl_pkg::CFG_SWITCH_THRESHOLD, 20'd1500);
    cfg_write(tmsl_pkg::CFG_LOG_INTERVAL, 20'd1);
    cfg_write(tmsl_pkg::CFG_FLUSH_INTERVAL, 20'd1000);
    cfg_write(tmsl_pkg::CFG_LPF_ALPHA, 20'd256);
    @(posedge clk);
    stalls_asked = stalls_asked + 1;
    queue_random(130);
    drain();

    if (errors == 0 && rows_due.size() == 0) begin
      $display("[telemetry_maxhold_snapshot_logger_core] OK");
    end else begin
      $display("[telemetry_maxhold_snapshot_logger_core] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tmsl_pkg.sv
rtl/tmsl_front.sv
rtl/tmsl_cmdq.sv
rtl/tmsl_back.sv
rtl/telemetry_maxhold_snapshot_logger_core.sv
tb/telemetry_maxhold_snapshot_logger_core_test.sv
